// ===== rtl/core/lorq_pkg.sv =====
// Package for the Lamport-ordered request queue: widths, function codes,
// register indexes and parameter defaults. No dependencies.
`timescale 1ns / 1ps
package lorq_pkg;
    localparam int MAX_PROCS_DEF  = 16;
    localparam int STAMP_BITS_DEF = 32;
    localparam int TS_W    = 32;
    localparam int RANK_W  = 4;
    localparam int AMT_W   = 8;
    localparam int TOT_W   = 12;
    localparam int PC_W    = 5;
    localparam int CFG_W   = 12;
    localparam int IDX_W   = 2;
    localparam logic [TOT_W-1:0] TOT_MAX = '1;

    typedef enum logic [2:0] {
        FN_RIBBON  = 3'd0,
        FN_HORSE   = 3'd1,
        FN_ACK     = 3'd2,
        FN_RELEASE = 3'd3,
        FN_QUERY   = 3'd4
    } func_t;

    localparam logic [IDX_W-1:0] REG_OWN_RANK     = 2'd0;
    localparam logic [IDX_W-1:0] REG_PROC_COUNT   = 2'd1;
    localparam logic [IDX_W-1:0] REG_RIBBON_LIMIT = 2'd2;
    localparam logic [IDX_W-1:0] REG_HORSE_LIMIT  = 2'd3;

    // Walk codes for a request table.
    localparam logic [1:0] OP_INS  = 2'd0;
    localparam logic [1:0] OP_REM  = 2'd1;
    localparam logic [1:0] OP_SCAN = 2'd2;

    // Configuration as seen by the table engine.
    typedef struct packed {
        logic [RANK_W-1:0] own_rank;
        logic [TOT_W-1:0]  ribbon_limit;
        logic [PC_W-1:0]   horse_limit;
    } cfg_t;
endpackage

// ===== rtl/core/lorq_table.sv =====
// One sorted request table held in a synchronous memory, with insert, remove
// and scan walks driven by a small sequencer. Depends on lorq_pkg.
`timescale 1ns / 1ps
module lorq_table #(
    parameter int DEPTH = 16,
    parameter int SW    = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      go,
    input  logic [1:0]                op,      // 0 insert, 1 remove, 2 scan
    input  logic [SW-1:0]             key_stamp,
    input  logic [lorq_pkg::RANK_W-1:0] key_rank,
    input  logic [lorq_pkg::AMT_W-1:0]  key_amt,
    output logic                      done,
    output logic [$clog2(DEPTH+1)-1:0] found_pos,  // 1-based, 0 absent
    output logic [lorq_pkg::TOT_W-1:0] ahead_sum
);
    import lorq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    typedef struct packed {
        logic [SW-1:0]     stamp;
        logic [RANK_W-1:0] rank;
        logic [AMT_W-1:0]  amt;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_EXE  = 4'b0100,
        S_DONE = 4'b1000
    } st_t;

    entry_t mem [DEPTH];
    entry_t rd_q;
    st_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] r_reg, r_next;       // read pointer
    logic [CW-1:0] w_reg, w_next;       // write pointer
    logic [1:0] op_reg;
    entry_t key_reg;
    logic stop_reg, stop_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [TOT_W-1:0] sum_reg, sum_next;
    logic we;
    logic [AW-1:0] wa;
    entry_t wd;
    logic [AW-1:0] ra;
    logic [TOT_W:0] add;
    logic key_first;

    // Insertion runs from the tail downwards, shifting larger entries up.
    assign ra = (op_reg == OP_INS) ? AW'(r_reg - CW'(1)) : r_reg[AW-1:0];
    assign key_first = (key_reg.stamp != rd_q.stamp) ? (key_reg.stamp < rd_q.stamp)
                                                     : (key_reg.rank < rd_q.rank);
    assign add = {1'b0, sum_reg} + (TOT_W+1)'(rd_q.amt);

    // Memory with registered read.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rd_q <= mem[ra];
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        r_next = r_reg;
        w_next = w_reg;
        stop_next = stop_reg;
        pos_next = pos_reg;
        sum_next = sum_reg;
        we = 1'b0;
        wa = w_reg[AW-1:0];
        wd = key_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    pos_next = '0;
                    sum_next = '0;
                    stop_next = 1'b0;
                    if (op == OP_INS)
                    begin
                        r_next = count_reg;
                        w_next = count_reg;
                        state_next = (count_reg >= CW'(DEPTH)) ? S_DONE
                                   : (count_reg == '0) ? S_EXE : S_RD;
                    end
                    else
                    begin
                        r_next = '0;
                        w_next = '0;
                        state_next = (count_reg == '0) ? S_DONE : S_RD;
                    end
                end
            end
            S_RD:
                state_next = S_EXE;
            S_EXE:
            begin
                if (op_reg == OP_INS)
                begin
                    if (r_reg != '0 && key_first)
                    begin
                        we = 1'b1;
                        wd = rd_q;
                        r_next = r_reg - CW'(1);
                        w_next = w_reg - CW'(1);
                        state_next = (r_reg == CW'(1)) ? S_EXE : S_RD;
                    end
                    else
                    begin
                        we = 1'b1;
                        wd = key_reg;
                        count_next = count_reg + CW'(1);
                        state_next = S_DONE;
                    end
                end
                else if (op_reg == OP_REM)
                begin
                    if (rd_q.rank != key_reg.rank)
                    begin
                        we = 1'b1;
                        wd = rd_q;
                        w_next = w_reg + CW'(1);
                    end
                    r_next = r_reg + CW'(1);
                    if (r_reg + CW'(1) >= count_reg)
                    begin
                        count_next = (rd_q.rank != key_reg.rank) ? w_reg + CW'(1) : w_reg;
                        state_next = S_DONE;
                    end
                    else
                        state_next = S_RD;
                end
                else
                begin
                    if (!stop_reg && rd_q.rank == key_reg.rank)
                    begin
                        stop_next = 1'b1;
                        pos_next = r_reg + CW'(1);
                    end
                    else if (!stop_reg)
                        sum_next = add[TOT_W] ? TOT_MAX : add[TOT_W-1:0];
                    r_next = r_reg + CW'(1);
                    state_next = (r_reg + CW'(1) >= count_reg) ? S_DONE : S_RD;
                end
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        w_reg <= w_next;
        stop_reg <= stop_next;
        pos_reg <= pos_next;
        sum_reg <= sum_next;
        if (state_reg == S_IDLE && go)
        begin
            op_reg <= op;
            key_reg <= '{stamp: key_stamp, rank: key_rank, amt: key_amt};
        end
    end

    assign done = (state_reg == S_DONE);
    assign found_pos = pos_reg;
    assign ahead_sum = sum_reg;

    // The table never holds more entries than it has rows.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH)) else $error("table count overflow");
    // A walk always finishes by passing through the done state.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |=> state_reg == S_IDLE) else $error("done not one cycle");
    // A write never happens outside the execute state.
    a_we_exe: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> state_reg == S_EXE) else $error("stray table write");
endmodule

// ===== rtl/core/lamport_ordered_request_queue_unit.sv =====
// Top level of the Lamport-ordered request queue: clock, ack counter,
// registers and control over two lorq_table instances. Depends on lorq_pkg.
`timescale 1ns / 1ps
// Usage: pulse start with func, source_rank, timestamp and amount while busy
// is low; the request is taken at that edge and busy rises. When the work is
// done, result_valid is high for exactly one cycle with all result fields,
// and busy falls in the same cycle, so a new request can be given next.
// Walk length depends on the request: ack and unused codes do no table walk,
// nor does a request into a full table; other requests walk their own table
// down from the tail, shifting entries until a comparison stops the walk;
// release and query walk every stored entry of both tables, each entry read
// through the single read port of its table memory, which has a registered
// read. The receiver cannot stall: each result is presented once.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// must only be made while busy is low. Reset empties both tables, clears the
// clock and ack count and restores the register defaults (rank 0, 16
// processes, ribbon limit 10, horse limit 5); no clearing pass is needed.
module lamport_ordered_request_queue_unit #(
    parameter int MAX_PROCS  = lorq_pkg::MAX_PROCS_DEF,
    parameter int STAMP_BITS = lorq_pkg::STAMP_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [lorq_pkg::IDX_W-1:0]  cfg_index,
    input  logic [lorq_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  func,
    input  logic [lorq_pkg::RANK_W-1:0] source_rank,
    input  logic [lorq_pkg::TS_W-1:0]   timestamp,
    input  logic [lorq_pkg::AMT_W-1:0]  amount,
    output logic                        result_valid,
    output logic                        reply_valid,
    output logic [lorq_pkg::TS_W-1:0]   reply_timestamp,
    output logic [4:0]                  horse_position,
    output logic [lorq_pkg::TOT_W-1:0]  ribbon_total,
    output logic                        ribbon_granted,
    output logic                        horse_granted,
    output logic                        acks_complete
);
    import lorq_pkg::*;

    localparam int CW = $clog2(MAX_PROCS+1);

    typedef enum logic [3:0] {
        M_IDLE = 4'b0001,
        M_GO   = 4'b0010,
        M_WAIT = 4'b0100,
        M_OUT  = 4'b1000
    } mst_t;

    mst_t state_reg;
    cfg_t cfg_reg;
    logic [PC_W-1:0] pc_reg, ack_reg;
    logic [STAMP_BITS-1:0] clock_reg;
    func_t func_reg;
    logic [RANK_W-1:0] src_reg;
    logic [STAMP_BITS-1:0] ts_reg;
    logic [AMT_W-1:0] amt_reg;
    logic r_done_reg, h_done_reg;
    logic r_go, h_go, r_done, h_done;
    logic [1:0] r_op, h_op;
    logic [RANK_W-1:0] key_rank;
    logic [CW-1:0] r_pos, h_pos;
    logic [TOT_W-1:0] r_sum, h_sum;
    logic [TOT_W:0] tot;
    logic [TOT_W-1:0] tot_sat;
    logic [4:0] hpos5;
    logic is_req, is_q;

    assign is_req = (func_reg == FN_RIBBON) || (func_reg == FN_HORSE);
    assign is_q = (func_reg == FN_QUERY);
    assign key_rank = is_q ? cfg_reg.own_rank : src_reg;
    assign r_op = (func_reg == FN_RIBBON) ? OP_INS : (func_reg == FN_RELEASE) ? OP_REM : OP_SCAN;
    assign h_op = (func_reg == FN_HORSE) ? OP_INS : (func_reg == FN_RELEASE) ? OP_REM : OP_SCAN;
    assign r_go = (state_reg == M_GO) &&
        (func_reg == FN_RIBBON || func_reg == FN_RELEASE || is_q);
    assign h_go = (state_reg == M_GO) &&
        (func_reg == FN_HORSE || func_reg == FN_RELEASE || is_q);

    lorq_table #(.DEPTH(MAX_PROCS), .SW(STAMP_BITS)) u_ribbon (
        .clk, .rst_n, .go(r_go), .op(r_op), .key_stamp(ts_reg), .key_rank(key_rank),
        .key_amt(amt_reg), .done(r_done), .found_pos(r_pos), .ahead_sum(r_sum));
    lorq_table #(.DEPTH(MAX_PROCS), .SW(STAMP_BITS)) u_horse (
        .clk, .rst_n, .go(h_go), .op(h_op), .key_stamp(ts_reg), .key_rank(key_rank),
        .key_amt(8'd0), .done(h_done), .found_pos(h_pos), .ahead_sum(h_sum));

    // Query figures from the two walks.
    assign tot = {1'b0, r_sum} + (TOT_W+1)'(amt_reg);
    assign tot_sat = tot[TOT_W] ? TOT_MAX : tot[TOT_W-1:0];
    assign hpos5 = 5'(h_pos);

    // Registers, control and request sequencing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            cfg_reg <= '{own_rank: '0, ribbon_limit: TOT_W'(10), horse_limit: 5'd5};
            pc_reg <= 5'd16;
            ack_reg <= '0;
            clock_reg <= '0;
            r_done_reg <= 1'b0;
            h_done_reg <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_OWN_RANK:     cfg_reg.own_rank <= cfg_data[RANK_W-1:0];
                    REG_PROC_COUNT:   pc_reg <= cfg_data[PC_W-1:0];
                    REG_RIBBON_LIMIT: cfg_reg.ribbon_limit <= cfg_data[TOT_W-1:0];
                    REG_HORSE_LIMIT:  cfg_reg.horse_limit <= cfg_data[PC_W-1:0];
                    default: ;
                endcase
            end
            case (state_reg)
                M_IDLE:
                    if (start)
                        state_reg <= M_GO;
                M_GO:
                begin
                    r_done_reg <= !r_go;
                    h_done_reg <= !h_go;
                    if (is_req)
                        clock_reg <= ((ts_reg > clock_reg) ? ts_reg : clock_reg)
                                     + STAMP_BITS'(1);
                    if (func_reg == FN_ACK && ack_reg < pc_reg)
                        ack_reg <= ack_reg + PC_W'(1);
                    state_reg <= M_WAIT;
                end
                M_WAIT:
                begin
                    if (r_done) r_done_reg <= 1'b1;
                    if (h_done) h_done_reg <= 1'b1;
                    if ((r_done_reg || r_done) && (h_done_reg || h_done))
                        state_reg <= M_OUT;
                end
                M_OUT:
                begin
                    result_valid <= 1'b1;
                    state_reg <= M_IDLE;
                end
                default:
                    state_reg <= M_IDLE;
            endcase
        end
    end

    // Request capture and result payload.
    always_ff @(posedge clk)
    begin
        if (state_reg == M_IDLE && start)
        begin
            func_reg <= func_t'(func);
            src_reg <= source_rank;
            ts_reg <= STAMP_BITS'(timestamp);
            amt_reg <= amount;
        end
        if (state_reg == M_OUT)
        begin
            reply_valid <= is_req;
            reply_timestamp <= TS_W'(clock_reg);
            horse_position <= is_q ? hpos5 : 5'd0;
            ribbon_total <= is_q ? tot_sat : '0;
            ribbon_granted <= is_q && (tot_sat <= cfg_reg.ribbon_limit);
            horse_granted <= is_q && (hpos5 != 5'd0) && (hpos5 <= cfg_reg.horse_limit);
            acks_complete <= (ack_reg >= pc_reg);
        end
    end

    assign busy = (state_reg != M_IDLE);

    // A result follows only the output state.
    a_res: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg) == M_OUT) else $error("stray result");
    // Acks never pass the process count by counting.
    a_ack: assert property (@(posedge clk) disable iff (!rst_n)
        $past(state_reg) == M_GO && $past(func_reg) == FN_ACK && $past(ack_reg) < $past(pc_reg)
        && !$past(cfg_we) |-> ack_reg <= pc_reg) else $error("ack overrun");
    // Busy holds while a request is in flight.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != M_IDLE |-> busy) else $error("busy dropped");
endmodule
